/* src/srd_pkg.sv */
// Shared types and constants for the sprite run-length row decoder.
// No dependencies.
package srd_pkg;

  localparam int MaxSideDefault = 4096;
  localparam int PosW           = 13;
  localparam int OutW           = 12;
  localparam int ByteW          = 8;
  localparam int HdrW           = 24;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_IMAGE_END = 2'd1,
    KIND_BAD_SIZE  = 2'd2,
    KIND_DROPPED   = 2'd3
  } result_kind_t;

  typedef enum logic {
    CFG_END_IMAGE = 1'b0,
    CFG_END_ROW   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             record_start;
  } srd_item_t;

endpackage

/* src/srd_in_reg.sv */
// Input register stage for the sprite decoder: holds one accepted transaction.
// Depends on srd_pkg.
module srd_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  srd_pkg::srd_item_t in_item,
  output logic              held_valid,
  output srd_pkg::srd_item_t held_item,
  input  logic              take
);
  import srd_pkg::*;

  logic held_valid_next;

  assign in_ready = !held_valid || take;

  always_comb begin
    held_valid_next = held_valid;
    if (in_valid && in_ready) begin
      held_valid_next = 1'b1;
    end else if (take) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

/* src/srd_core.sv */
// Decode state machine and result register for the sprite decoder.
// Depends on srd_pkg.
module srd_core #(
  parameter int MAX_SIDE = srd_pkg::MaxSideDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [srd_pkg::ByteW-1:0]   cfg_data,
  input  logic                        item_valid,
  input  srd_pkg::srd_item_t          item,
  output logic                        take,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  result_kind,
  output logic [srd_pkg::OutW-1:0]    pixel_x,
  output logic [srd_pkg::OutW-1:0]    pixel_y,
  output logic [srd_pkg::ByteW-1:0]   color_index
);
  import srd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_CMD    = 3'd2,
    PH_COUNT  = 3'd3,
    PH_PIXELS = 3'd4
  } phase_t;

  localparam logic [31:0] MaxSideW = 32'(MAX_SIDE);

  function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
                                              input logic [ByteW-1:0] b);
    logic [PosW:0] s;
    s = {1'b0, a} + {{(PosW + 1 - ByteW){1'b0}}, b};
    return s[PosW] ? {PosW{1'b1}} : s[PosW-1:0];
  endfunction

  function automatic logic [OutW-1:0] clip_out(input logic [PosW-1:0] v);
    return v[PosW-1] ? {OutW{1'b1}} : v[OutW-1:0];
  endfunction

  phase_t             phase, phase_next, ph;
  logic [3:0]         header_count, header_count_next, hc;
  logic [HdrW-1:0]    header_word, header_word_next, hw;
  logic [PosW-1:0]    image_width, image_width_next;
  logic [PosW-1:0]    image_height, image_height_next;
  logic [PosW-1:0]    column, column_next;
  logic [PosW-1:0]    row, row_next;
  logic [ByteW-1:0]   pixels_left, pixels_left_next;
  logic [ByteW-1:0]   end_image_code, end_row_code;
  logic               out_valid_next;
  logic [1:0]         result_kind_next;
  logic [OutW-1:0]    pixel_x_next, pixel_y_next;
  logic [ByteW-1:0]   color_index_next;
  logic               emit;
  logic [ByteW-1:0]   b;
  logic [1:0]         pos;
  logic [31:0]        full_word;
  logic               side_ok;
  logic               in_bounds;

  assign take = item_valid && (!out_valid || out_ready);
  assign b    = item.data_byte;
  assign ph   = item.record_start ? PH_HEADER : phase;
  assign hc   = item.record_start ? 4'd0 : header_count;
  assign hw   = item.record_start ? '0 : header_word;
  assign pos  = hc[1:0];
  assign full_word = {b, hw};
  assign side_ok   = (full_word != 32'd0) && (full_word <= MaxSideW);
  assign in_bounds = (column < image_width) && (row < image_height);

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    header_word_next  = header_word;
    image_width_next  = image_width;
    image_height_next = image_height;
    column_next       = column;
    row_next          = row;
    pixels_left_next  = pixels_left;
    emit              = 1'b0;
    result_kind_next  = result_kind;
    pixel_x_next      = pixel_x;
    pixel_y_next      = pixel_y;
    color_index_next  = color_index;

    if (take) begin
      unique case (ph)
        PH_HEADER: begin
          phase_next = PH_HEADER;
          unique case (pos)
            2'd0: header_word_next = {{(HdrW - ByteW){1'b0}}, b};
            2'd1: header_word_next = {hw[HdrW-1:16], b, hw[7:0]};
            2'd2: header_word_next = {b, hw[15:0]};
            2'd3: header_word_next = hw;
            default: header_word_next = hw;
          endcase
          if (hc == 4'd3) begin
            image_width_next = side_ok ? full_word[PosW-1:0] : '0;
          end
          if (hc == 4'd7) begin
            image_height_next = side_ok ? full_word[PosW-1:0] : '0;
          end
          if (hc == 4'd15) begin
            header_count_next = 4'd0;
            column_next       = '0;
            row_next          = '0;
            pixels_left_next  = '0;
            if ((image_width == '0) || (image_height == '0)) begin
              phase_next       = PH_IDLE;
              emit             = 1'b1;
              result_kind_next = KIND_BAD_SIZE;
              pixel_x_next     = '0;
              pixel_y_next     = '0;
              color_index_next = '0;
            end else begin
              phase_next = PH_CMD;
            end
          end else begin
            header_count_next = hc + 4'd1;
          end
        end
        PH_CMD: begin
          if (b == end_image_code) begin
            phase_next       = PH_IDLE;
            emit             = 1'b1;
            result_kind_next = KIND_IMAGE_END;
            pixel_x_next     = '0;
            pixel_y_next     = '0;
            color_index_next = '0;
          end else if (b == end_row_code) begin
            column_next = '0;
            row_next    = sat_add(row, 8'd1);
          end else begin
            column_next = sat_add(column, b);
            phase_next  = PH_COUNT;
          end
        end
        PH_COUNT: begin
          pixels_left_next = b;
          phase_next       = (b == '0) ? PH_CMD : PH_PIXELS;
        end
        PH_PIXELS: begin
          emit             = 1'b1;
          result_kind_next = in_bounds ? KIND_PIXEL : KIND_DROPPED;
          pixel_x_next     = clip_out(column);
          pixel_y_next     = clip_out(row);
          color_index_next = b;
          column_next      = sat_add(column, 8'd1);
          pixels_left_next = pixels_left - 8'd1;
          if (pixels_left_next == '0) begin
            phase_next = PH_CMD;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (take && emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      header_count   <= '0;
      header_word    <= '0;
      image_width    <= '0;
      image_height   <= '0;
      column         <= '0;
      row            <= '0;
      pixels_left    <= '0;
      end_image_code <= 8'd255;
      end_row_code   <= 8'd254;
      out_valid      <= 1'b0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      header_word  <= header_word_next;
      image_width  <= image_width_next;
      image_height <= image_height_next;
      column       <= column_next;
      row          <= row_next;
      pixels_left  <= pixels_left_next;
      out_valid    <= out_valid_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_END_IMAGE: end_image_code <= cfg_data;
          CFG_END_ROW:   end_row_code   <= cfg_data;
          default:       end_row_code   <= end_row_code;
        endcase
      end
    end
    result_kind <= result_kind_next;
    pixel_x     <= pixel_x_next;
    pixel_y     <= pixel_y_next;
    color_index <= color_index_next;
  end

endmodule

/* src/sprite_rle_row_decoder.sv */
// Sprite run-length row decoder: one record byte per transaction in, at most one result out.
// The byte enters the input register and its result the result register once the
// result slot is free. A stalled result holds the core.
// Throughput: one byte per cycle unless a result stalls; one input and one result register.
// Reset: synchronous; decoder idles until a record start, end codes return to 255 and 254.
// Depends on srd_pkg, srd_in_reg and srd_core.
module sprite_rle_row_decoder #(
  parameter int MAX_SIDE = srd_pkg::MaxSideDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [srd_pkg::ByteW-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [srd_pkg::ByteW-1:0] data_byte,
  input  logic                      record_start,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                result_kind,
  output logic [srd_pkg::OutW-1:0]  pixel_x,
  output logic [srd_pkg::OutW-1:0]  pixel_y,
  output logic [srd_pkg::ByteW-1:0] color_index
);
  import srd_pkg::*;

  srd_item_t in_item;
  srd_item_t held_item;
  logic      held_valid;
  logic      take;

  assign in_item.data_byte    = data_byte;
  assign in_item.record_start = record_start;

  srd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  srd_core #(
    .MAX_SIDE (MAX_SIDE)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (held_valid),
    .item        (held_item),
    .take        (take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .color_index (color_index)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sprite_rle_row_decoder: directed table, saturation record,
// then random records per end-code setting; both sides idle at random, not in the last.
// Depends on srd_pkg and the decoder RTL.
module tb_top;
  import srd_pkg::*;

  localparam int MaxSide      = MaxSideDefault;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 4;
  localparam int PhaseItems   = 60;

  typedef enum logic [2:0] {
    DEC_IDLE,
    DEC_HEADER,
    DEC_CMD,
    DEC_COUNT,
    DEC_PIXELS
  } dec_phase_t;

  typedef struct packed {
    result_kind_t    kind;
    logic [OutW-1:0] x;
    logic [OutW-1:0] y;
    logic [7:0]      c;
  } sprite_px_t;

  typedef struct packed {
    logic [7:0] b;
    logic       st;
    logic       typed;
    logic       has;
    sprite_px_t px;
  } dir_row_t;

  localparam sprite_px_t NoPx = '{KIND_PIXEL, 12'd0, 12'd0, 8'd0};

  localparam dir_row_t DirectedRows [29] = '{
    '{8'h55, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h13, 1'b1, 1'b1, 1'b0, NoPx},
    '{8'h00, 1'b1, 1'b1, 1'b0, NoPx},
    '{8'h10, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h01, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'hFF, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'hFF, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'hFF, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'hFF, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b1, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoPx},
    '{8'h02, 1'b0, 1'b0, 1'b0, NoPx},
    '{8'hFF, 1'b0, 1'b1, 1'b1, '{KIND_PIXEL, 12'd0, 12'd0, 8'hFF}},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{KIND_PIXEL, 12'd1, 12'd0, 8'h00}},
    '{8'hFE, 1'b0, 1'b0, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoPx},
    '{8'h00, 1'b0, 1'b0, 1'b0, NoPx},
    '{8'h01, 1'b0, 1'b0, 1'b0, NoPx},
    '{8'h33, 1'b0, 1'b1, 1'b1, '{KIND_DROPPED, 12'd0, 12'd1, 8'h33}},
    '{8'hFF, 1'b0, 1'b1, 1'b1, '{KIND_IMAGE_END, 12'd0, 12'd0, 8'h00}}
  };

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             cfg_we       = 1'b0;
  logic             cfg_index    = 1'b0;
  logic [ByteW-1:0] cfg_data     = '0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] data_byte    = '0;
  logic             record_start = 1'b0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  logic [1:0]       result_kind;
  logic [OutW-1:0]  pixel_x;
  logic [OutW-1:0]  pixel_y;
  logic [ByteW-1:0] color_index;

  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left = 0;
  int cycle_cnt  = 0;
  int mismatches = 0;

  sprite_px_t expected_px [$];
  srd_item_t  rec_q [$];

  dec_phase_t  dec_phase;
  logic [3:0]  hdr_cnt;
  logic [31:0] hdr_word;
  logic [12:0] img_w, img_h, pos_col, pos_row;
  logic [7:0]  px_left, code_img, code_row;

  sprite_rle_row_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .record_start (record_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .color_index  (color_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [12:0] sat_pos(input logic [12:0] a, input logic [7:0] d);
    logic [13:0] s;
    s = {1'b0, a} + {6'd0, d};
    return (s > 14'd8191) ? 13'h1FFF : s[12:0];
  endfunction

  function automatic logic [OutW-1:0] clip_out(input logic [12:0] v);
    return v[12] ? 12'hFFF : v[11:0];
  endfunction

  function automatic void queue_result(input sprite_px_t px);
    expected_px = {expected_px, px};
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic st, output logic got,
                             output sprite_px_t px);
    logic [1:0] pos;
    logic       size_ok;
    logic       in_img;
    got = 1'b0;
    px  = NoPx;
    if (st) begin
      dec_phase = DEC_HEADER;
      hdr_cnt   = '0;
      hdr_word  = '0;
    end
    case (dec_phase)
      DEC_HEADER: begin
        pos = hdr_cnt[1:0];
        if (pos == 2'd0) hdr_word = '0;
        hdr_word[pos*8 +: 8] = b;
        size_ok = (hdr_word != 32'd0) && (hdr_word <= 32'(MaxSide));
        if (pos == 2'd3) begin
          if (hdr_cnt == 4'd3) img_w = size_ok ? hdr_word[12:0] : 13'd0;
          else if (hdr_cnt == 4'd7) img_h = size_ok ? hdr_word[12:0] : 13'd0;
        end
        if (hdr_cnt == 4'd15) begin
          hdr_cnt = '0;
          pos_col = '0;
          pos_row = '0;
          px_left = '0;
          if (img_w == 13'd0 || img_h == 13'd0) begin
            dec_phase = DEC_IDLE;
            got       = 1'b1;
            px.kind   = KIND_BAD_SIZE;
          end else begin
            dec_phase = DEC_CMD;
          end
        end else begin
          hdr_cnt = hdr_cnt + 4'd1;
        end
      end
      DEC_CMD: begin
        if (b == code_img) begin
          dec_phase = DEC_IDLE;
          got       = 1'b1;
          px.kind   = KIND_IMAGE_END;
        end else if (b == code_row) begin
          pos_col = '0;
          pos_row = sat_pos(pos_row, 8'd1);
        end else begin
          pos_col   = sat_pos(pos_col, b);
          dec_phase = DEC_COUNT;
        end
      end
      DEC_COUNT: begin
        px_left   = b;
        dec_phase = (b == 8'd0) ? DEC_CMD : DEC_PIXELS;
      end
      DEC_PIXELS: begin
        in_img  = (pos_col < img_w) && (pos_row < img_h);
        got     = 1'b1;
        px.kind = in_img ? KIND_PIXEL : KIND_DROPPED;
        px.x    = clip_out(pos_col);
        px.y    = clip_out(pos_row);
        px.c    = b;
        pos_col = sat_pos(pos_col, 8'd1);
        px_left = px_left - 8'd1;
        if (px_left == 8'd0) dec_phase = DEC_CMD;
      end
      default: begin
        dec_phase = DEC_IDLE;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic st);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    record_start <= st;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_record();
    logic       got;
    sprite_px_t px;
    foreach (rec_q[i]) begin
      send_byte(rec_q[i].data_byte, rec_q[i].record_start);
      decode_byte(rec_q[i].data_byte, rec_q[i].record_start, got, px);
      if (got) queue_result(px);
    end
    rec_q.delete();
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_px.size() == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_END_IMAGE) code_img = val;
    else code_row = val;
  endtask

  function automatic void put(input logic [7:0] b, input logic st);
    rec_q = {rec_q, srd_item_t'({b, st})};
  endfunction

  function automatic void put_word(input logic [31:0] w, input logic first);
    put(w[7:0], first);
    put(w[15:8], 1'b0);
    put(w[23:16], 1'b0);
    put(w[31:24], 1'b0);
  endfunction

  function automatic logic [31:0] pick_side();
    case ($urandom_range(0, 39))
      0: return 32'd0;
      1: return 32'(MaxSide);
      2: return 32'(MaxSide + 1);
      3: return $urandom;
      4: return $urandom_range(13, 300);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic build_record();
    int rows, runs, skip, cnt, cut;
    put_word(pick_side(), 1'b1);
    put_word(pick_side(), 1'b0);
    put_word($urandom, 1'b0);
    put_word($urandom, 1'b0);
    rows = $urandom_range(1, 4);
    for (int r = 0; r < rows; r++) begin
      runs = $urandom_range(0, 3);
      for (int k = 0; k < runs; k++) begin
        skip = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
        while (skip == int'(code_img) || skip == int'(code_row)) skip = $urandom_range(0, 8);
        case ($urandom_range(0, 39))
          0: cnt = 255;
          1, 2, 3, 4: cnt = $urandom_range(7, 40);
          default: cnt = $urandom_range(0, 6);
        endcase
        put(8'(skip), 1'b0);
        put(8'(cnt), 1'b0);
        repeat (cnt) put(8'($urandom_range(0, 255)), 1'b0);
      end
      if (r < rows - 1) put(code_row, 1'b0);
    end
    put(code_img, 1'b0);
    // break some records: cut them short or corrupt a body byte
    case ($urandom_range(0, 9))
      0: begin
        cut = $urandom_range(1, rec_q.size() - 1);
        while (rec_q.size() > cut) void'(rec_q.pop_back());
      end
      1: rec_q[$urandom_range(16, rec_q.size() - 1)].data_byte = 8'($urandom_range(0, 255));
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left = stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sprite_px_t seen, want;
    if (!rst && out_valid && out_ready) begin
      seen.kind = result_kind_t'(result_kind);
      seen.x    = pixel_x;
      seen.y    = pixel_y;
      seen.c    = color_index;
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d x=%0d y=%0d color=%0d",
                   seen.kind, seen.x, seen.y, seen.c);
      end else begin
        want = expected_px.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind/x/y/color %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     want.kind, want.x, want.y, want.c, seen.kind, seen.x, seen.y, seen.c);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic       got;
    sprite_px_t px;
    int         phase_items;
    logic [7:0] img_codes [6];
    logic [7:0] row_codes [6];
    img_codes = '{8'd0, 8'd37, 8'd255, 8'd128, 8'($urandom_range(0, 255)), 8'd255};
    row_codes = '{8'd255, 8'd37, 8'd0, 8'd200, 8'($urandom_range(0, 255)), 8'd254};
    code_img  = 8'd255;
    code_row  = 8'd254;
    dec_phase = DEC_IDLE;
    hdr_cnt   = '0;
    hdr_word  = '0;
    img_w     = '0;
    img_h     = '0;
    pos_col   = '0;
    pos_row   = '0;
    px_left   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DirectedRows); i++) begin
      send_byte(DirectedRows[i].b, DirectedRows[i].st);
      decode_byte(DirectedRows[i].b, DirectedRows[i].st, got, px);
      if (DirectedRows[i].typed) begin
        if (DirectedRows[i].has) queue_result(DirectedRows[i].px);
      end else if (got) begin
        queue_result(px);
      end
    end

    // saturate the column, then cross the right edge on the next row
    put_word(32'd16, 1'b1);
    put_word(32'(MaxSide), 1'b0);
    put_word($urandom, 1'b0);
    put_word($urandom, 1'b0);
    repeat (33) begin
      put(8'd253, 1'b0);
      put(8'd0, 1'b0);
    end
    put(8'd0, 1'b0);
    put(8'd2, 1'b0);
    put(8'($urandom_range(0, 255)), 1'b0);
    put(8'($urandom_range(0, 255)), 1'b0);
    put(code_row, 1'b0);
    put(8'd15, 1'b0);
    put(8'd2, 1'b0);
    put(8'($urandom_range(0, 255)), 1'b0);
    put(8'($urandom_range(0, 255)), 1'b0);
    repeat (3) put(code_row, 1'b0);
    put(8'd0, 1'b0);
    put(8'd1, 1'b0);
    put(8'($urandom_range(0, 255)), 1'b0);
    put(code_img, 1'b0);
    send_record();

    for (int s = 0; s < 6; s++) begin
      drain_results();
      write_reg(CFG_END_IMAGE, img_codes[s]);
      write_reg(CFG_END_ROW, row_codes[s]);
      if (s == 5) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        build_record();
        phase_items += rec_q.size();
        // drop stray bytes on the link after the record
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)), 1'b0);
        send_record();
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
